FILE: hw/rtl/mpas_pkg.sv
// shared types, register codes, reset values and constant tables
// for the multichannel pid actuator servo; no dependencies
`default_nettype none

package mpas_pkg;

  typedef enum logic [2:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_INTEGRAL_GAIN = 3'd1,
    REG_DERIV_GAIN    = 3'd2,
    REG_HIGH_LIMIT    = 3'd3,
    REG_LOW_LIMIT     = 3'd4,
    REG_LENGTH_OFFSET = 3'd5,
    REG_TOP_RATIO     = 3'd6,
    REG_BOTTOM_RATIO  = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_OVER  = 2'd1,
    STAT_UNDER = 2'd2,
    STAT_FAULT = 2'd3
  } status_t;

  localparam logic [15:0] PROP_GAIN_RST     = 16'd3840;
  localparam logic [15:0] INTEGRAL_GAIN_RST = 16'd0;
  localparam logic [15:0] DERIV_GAIN_RST    = 16'd0;
  localparam logic [13:0] HIGH_LIMIT_RST    = 14'd11776;
  localparam logic [13:0] LOW_LIMIT_RST     = 14'd4608;
  localparam logic [13:0] LENGTH_OFFSET_RST = 14'd4352;
  localparam logic [8:0]  TOP_RATIO_RST     = 9'd192;
  localparam logic [8:0]  BOTTOM_RATIO_RST  = 9'd64;

  // code to q8.8 inches scale, 18 bits
  localparam logic [17:0] LEN_SCALE = 18'd201575;

  localparam int SUM_W  = 54;
  localparam int MUL_W  = 34;
  localparam int CLMP_W = 42;
  localparam int RPRD_W = 52;

  // per channel q2.14 scale
  function automatic logic [15:0] chan_scale(input logic [3:0] ch);
    logic [15:0] s;
    case (ch)
      4'd0:    s = 16'd17993;
      4'd1:    s = 16'd22910;
      4'd2:    s = 16'd15713;
      4'd3:    s = 16'd14500;
      4'd4:    s = 16'd17319;
      4'd5:    s = 16'd12716;
      default: s = 16'd16384;
    endcase
    return s;
  endfunction

  // positive sum with 16 fraction bits: round half up, saturate
  function automatic logic [15:0] round_pos(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] t;
    logic signed [SUM_W-17:0] r;
    t = v + SUM_W'(32768);
    r = t[SUM_W-1:16];
    if (r > (SUM_W-16)'(32767)) return 16'h7fff;
    return r[15:0];
  endfunction

  // non-positive product with 24 fraction bits: add half, truncate toward zero
  function automatic logic [15:0] round_neg(input logic signed [RPRD_W-1:0] v);
    logic signed [RPRD_W-1:0] t;
    logic signed [RPRD_W-1:0] u;
    logic signed [RPRD_W-25:0] r;
    t = v + RPRD_W'(24'h800000);
    if (!t[RPRD_W-1]) return 16'd0;
    u = t + RPRD_W'(24'hffffff);
    r = u[RPRD_W-1:24];
    if (r < -(RPRD_W-24)'(32768)) return 16'h8000;
    return r[15:0];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/multichannel_pid_actuator_servo_top.sv
// multichannel pid actuator servo, top level
// per-channel state in one synchronous memory, shared multiplier and
// bit-serial divider; uses mpas_pkg
//
// usage: one item on s_axis (channel, sensor code, setpoint, elapsed us,
// clear flag) gives exactly one item on m_axis (channel, top drive,
// bottom drive, status). registers are to be written through cfg_we/cfg_addr/
// cfg_wdata only while the block is idle; the block does not enforce this.
// items are worked one at a time. an item whose pid sum is not positive
// also passes ST_RT and ST_RB, which one whose sum is positive skips; the
// derivative waits in ST_DWAIT on the 25-step one-bit-per-cycle divider.
// an out-of-range channel or a limit or latched fault ends in ST_CHECK.
// results sit in an output register: the next item is accepted while a
// result waits, and only the finish of that next item waits on m_axis_tready.
// reset clears the fault latch, the registers to their defaults and the
// valid bit of every channel entry, so unwritten channels read as zero.
`default_nettype none

module multichannel_pid_actuator_servo_top #(
  parameter int CHANNELS    = 6,
  parameter int SENSOR_BITS = 12,
  localparam int IN_W  = ((SENSOR_BITS + 34 + 7) / 8) * 8,
  localparam int OUT_W = 40
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // channel, sensor_code, setpoint, elapsed_us, clear_history, zero fill
  input  wire logic [IN_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // out_channel, top_drive, bottom_drive, status, zero fill
  output logic [OUT_W-1:0]      m_axis_tdata,
  input  wire logic             cfg_we,
  input  wire logic [2:0]       cfg_addr,
  input  wire logic [15:0]      cfg_wdata
);

  localparam int SP_LSB  = 3 + SENSOR_BITS;
  localparam int DT_LSB  = SP_LSB + 14;
  localparam int CLR_BIT = DT_LSB + 16;
  localparam int LEN_W   = SENSOR_BITS + 2;
  localparam int ERR_W   = (SENSOR_BITS + 4 > 16) ? SENSOR_BITS + 4 : 16;
  localparam int QW      = ERR_W + 9;
  localparam int DCNT_W  = $clog2(QW + 1);
  localparam int IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MEM_W   = ERR_W + 48;
  localparam int SUM_W   = mpas_pkg::SUM_W;
  localparam int MUL_W   = mpas_pkg::MUL_W;
  localparam int CLMP_W  = mpas_pkg::CLMP_W;
  localparam int RPRD_W  = mpas_pkg::RPRD_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LEN, ST_CHECK, ST_ED, ST_INTEG, ST_PS, ST_PE, ST_IL, ST_IH,
    ST_IS, ST_DWAIT, ST_DM, ST_DS, ST_RND, ST_RT, ST_RB
  } state_t;

  state_t state;
  logic   rf_pending;

  // configuration
  logic [15:0] prop_gain, integral_gain, deriv_gain;
  logic [13:0] high_limit, low_limit, length_offset;
  logic [8:0]  top_ratio, bottom_ratio;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain     <= mpas_pkg::PROP_GAIN_RST;
      integral_gain <= mpas_pkg::INTEGRAL_GAIN_RST;
      deriv_gain    <= mpas_pkg::DERIV_GAIN_RST;
      high_limit    <= mpas_pkg::HIGH_LIMIT_RST;
      low_limit     <= mpas_pkg::LOW_LIMIT_RST;
      length_offset <= mpas_pkg::LENGTH_OFFSET_RST;
      top_ratio     <= mpas_pkg::TOP_RATIO_RST;
      bottom_ratio  <= mpas_pkg::BOTTOM_RATIO_RST;
    end else if (cfg_we) begin
      case (mpas_pkg::reg_idx_t'(cfg_addr))
        mpas_pkg::REG_PROP_GAIN:     prop_gain     <= cfg_wdata;
        mpas_pkg::REG_INTEGRAL_GAIN: integral_gain <= cfg_wdata;
        mpas_pkg::REG_DERIV_GAIN:    deriv_gain    <= cfg_wdata;
        mpas_pkg::REG_HIGH_LIMIT:    high_limit    <= cfg_wdata[13:0];
        mpas_pkg::REG_LOW_LIMIT:     low_limit     <= cfg_wdata[13:0];
        mpas_pkg::REG_LENGTH_OFFSET: length_offset <= cfg_wdata[13:0];
        mpas_pkg::REG_TOP_RATIO:     top_ratio     <= cfg_wdata[8:0];
        mpas_pkg::REG_BOTTOM_RATIO:  bottom_ratio  <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  // input decode
  logic [2:0]             in_ch;
  logic [4:0]             in_chx;
  logic                   in_range;
  logic [IDX_W-1:0]       in_idx;
  logic                   accept;

  assign in_ch    = s_axis_tdata[2:0];
  assign in_chx   = {2'b00, in_ch};
  assign in_range = in_chx < 5'(CHANNELS);
  assign in_idx   = in_range ? in_chx[IDX_W-1:0] : '0;
  assign s_axis_tready = (state == ST_IDLE) && !rf_pending;
  assign accept   = s_axis_tvalid && s_axis_tready;

  // item registers
  logic [2:0]               ch_q;
  logic [SENSOR_BITS-1:0]   code_q;
  logic signed [13:0]       sp_q;
  logic [15:0]              dt_q;
  logic                     clr_q;
  logic                     range_q;
  logic [IDX_W-1:0]         idx_q;

  // channel state memory: {previous error, integral}
  logic [MEM_W-1:0]         mem [CHANNELS];
  logic [CHANNELS-1:0]      vld;
  logic [MEM_W-1:0]         rd_data;
  logic                     rd_vld;
  logic                     mem_we;
  logic signed [47:0]       acc_c;
  logic signed [ERR_W-1:0]  err_q;

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= mem[in_idx];
    end
    if (mem_we) begin
      mem[idx_q] <= {err_q, acc_c};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (accept) rd_vld <= vld[in_idx];
      if (mem_we) vld[idx_q] <= 1'b1;
    end
  end

  logic signed [ERR_W-1:0] prev_eff;
  logic signed [47:0]      int_eff;
  assign prev_eff = (clr_q || !rd_vld) ? '0 : $signed(rd_data[MEM_W-1:48]);
  assign int_eff  = rd_vld ? $signed(rd_data[47:0]) : '0;

  // shared multiplier
  logic signed [MUL_W-1:0]   ma, mb;
  logic signed [2*MUL_W-1:0] mul_p;
  logic signed [QW:0]        q_c;
  logic [QW-1:0]             dv_quo;
  logic                      dv_neg;
  logic signed [47:0]        acc_q;

  assign q_c = dv_neg ? -$signed({1'b0, dv_quo}) : $signed({1'b0, dv_quo});

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      ST_LEN: begin
        ma = $signed(MUL_W'(code_q));
        mb = $signed(MUL_W'(mpas_pkg::LEN_SCALE));
      end
      ST_ED: begin
        ma = MUL_W'(err_q);
        mb = $signed(MUL_W'(dt_q));
      end
      ST_PS: begin
        ma = $signed(MUL_W'(prop_gain));
        mb = $signed(MUL_W'(mpas_pkg::chan_scale({1'b0, ch_q})));
      end
      ST_PE: begin
        ma = $signed(MUL_W'(mul_p[32:0]));
        mb = MUL_W'(err_q);
      end
      ST_IL: begin
        ma = $signed(MUL_W'(integral_gain));
        mb = $signed(MUL_W'(acc_q[23:0]));
      end
      ST_IH: begin
        ma = $signed(MUL_W'(integral_gain));
        mb = MUL_W'($signed(acc_q[47:24]));
      end
      ST_DM: begin
        ma = $signed(MUL_W'(deriv_gain));
        mb = MUL_W'(q_c);
      end
      default: ;
    endcase
  end

  // saturating integral update
  logic signed [48:0] acc_sum;
  assign acc_sum = {int_eff[47], int_eff} + mul_p[48:0];
  always_comb begin
    if (acc_sum[48] != acc_sum[47]) begin
      acc_c = acc_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end else begin
      acc_c = acc_sum[47:0];
    end
  end

  // length and error
  logic [LEN_W-1:0]        len_c;
  logic signed [ERR_W-1:0] err_c;
  assign len_c = mul_p[LEN_W+15:16];
  assign err_c = ERR_W'(sp_q) - $signed(ERR_W'(len_c)) + $signed(ERR_W'(length_offset));

  // divider operands
  logic signed [ERR_W:0] diff_c;
  logic [ERR_W:0]        mag_c;
  assign diff_c = ERR_W'(err_q) - ERR_W'(prev_eff);
  assign mag_c  = diff_c[ERR_W] ? 
                  (ERR_W + 1)'(-diff_c) : (ERR_W + 1)'(diff_c);

  logic [15:0]       dv_rem;
  logic [DCNT_W-1:0] dv_cnt;
  logic              dv_busy;
  logic [16:0]       dv_shift;
  logic [16:0]       dv_trial;
  assign dv_shift = {dv_rem, dv_quo[QW-1]};
  assign dv_trial = dv_shift - {1'b0, dt_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_busy <= 1'b0;
    end else if (state == ST_ED) begin
      dv_busy <= 1'b1;
      dv_cnt  <= DCNT_W'(QW);
      dv_rem  <= '0;
      dv_quo  <= {mag_c, 8'd0};
      dv_neg  <= diff_c[ERR_W];
    end else if (dv_busy) begin
      if (!dv_trial[16]) begin
        dv_rem <= dv_trial[15:0];
        dv_quo <= {dv_quo[QW-2:0], 1'b1};
      end else begin
        dv_rem <= dv_shift[15:0];
        dv_quo <= {dv_quo[QW-2:0], 1'b0};
      end
      dv_cnt <= dv_cnt - 1'b1;
      if (dv_cnt == DCNT_W'(1)) dv_busy <= 1'b0;
    end
  end

  // output rounding
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [CLMP_W-1:0] sclamp;
  logic signed [RPRD_W-1:0] rp;
  logic [39:0]              ilo_q;
  logic signed [65:0]       ifull;
  logic                     fault_q;
  logic [15:0]              top_q, bot_q;
  logic [1:0]               stat_q;

  assign sclamp = (sum_q < -(SUM_W'(64'sh100_0000_0000))) ?
                  -(CLMP_W'(64'sh100_0000_0000)) : sum_q[CLMP_W-1:0];
  assign ifull  = $signed({mul_p[41:0], 24'd0}) + $signed({26'd0, ilo_q});
  assign mem_we = (state == ST_INTEG);

  logic [2:0]  o_ch;
  logic [15:0] o_top, o_bot;
  logic [1:0]  o_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      rf_pending    <= 1'b0;
      m_axis_tvalid <= 1'b0;
      fault_q       <= 1'b0;
    end else begin
      mul_p <= ma * mb;
      // final hand-off to the output register, waits for space
      if (rf_pending && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
        o_ch          <= ch_q;
        o_top         <= top_q;
        o_bot         <= bot_q;
        o_stat        <= stat_q;
        rf_pending    <= 1'b0;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            ch_q    <= in_ch;
            code_q  <= s_axis_tdata[SP_LSB-1:3];
            sp_q    <= s_axis_tdata[DT_LSB-1:SP_LSB];
            dt_q    <= (s_axis_tdata[CLR_BIT-1:DT_LSB] == 16'd0) ?
                       16'd1 : s_axis_tdata[CLR_BIT-1:DT_LSB];
            clr_q   <= s_axis_tdata[CLR_BIT];
            range_q <= in_range;
            idx_q   <= in_idx;
            state   <= ST_LEN;
          end
        end
        ST_LEN: state <= ST_CHECK;
        ST_CHECK: begin
          top_q <= '0;
          bot_q <= '0;
          if (!range_q || fault_q) begin
            stat_q     <= fault_q ? mpas_pkg::STAT_FAULT : mpas_pkg::STAT_OK;
            rf_pending <= 1'b1;
            state      <= ST_IDLE;
          end else if (32'(len_c) > 32'(high_limit)) begin
            stat_q     <= mpas_pkg::STAT_OVER;
            fault_q    <= 1'b1;
            rf_pending <= 1'b1;
            state      <= ST_IDLE;
          end else if (32'(len_c) < 32'(low_limit)) begin
            stat_q     <= mpas_pkg::STAT_UNDER;
            fault_q    <= 1'b1;
            rf_pending <= 1'b1;
            state      <= ST_IDLE;
          end else begin
            stat_q <= mpas_pkg::STAT_OK;
            err_q  <= err_c;
            state  <= ST_ED;
          end
        end
        ST_ED:    state <= ST_INTEG;
        ST_INTEG: begin
          acc_q <= acc_c;
          state <= ST_PS;
        end
        ST_PS: state <= ST_PE;
        ST_PE: state <= ST_IL;
        ST_IL: begin
          sum_q <= mul_p[SUM_W+13:14];
          state <= ST_IH;
        end
        ST_IH: begin
          ilo_q <= mul_p[39:0];
          state <= ST_IS;
        end
        ST_IS: begin
          sum_q <= sum_q + SUM_W'($signed(ifull[65:14]));
          state <= ST_DWAIT;
        end
        ST_DWAIT: begin
          if (!dv_busy) state <= ST_DM;
        end
        ST_DM: state <= ST_DS;
        ST_DS: begin
          sum_q <= sum_q - mul_p[SUM_W+7:8];
          state <= ST_RND;
        end
        ST_RND: begin
          if (sum_q > 0) begin
            top_q      <= mpas_pkg::round_pos(sum_q);
            bot_q      <= mpas_pkg::round_pos(sum_q);
            rf_pending <= 1'b1;
            state      <= ST_IDLE;
          end else begin
            rp    <= sclamp * $signed({1'b0, top_ratio});
            state <= ST_RT;
          end
        end
        ST_RT: begin
          top_q <= mpas_pkg::round_neg(rp);
          rp    <= sclamp * $signed({1'b0, bottom_ratio});
          state <= ST_RB;
        end
        ST_RB: begin
          bot_q      <= mpas_pkg::round_neg(rp);
          rf_pending <= 1'b1;
          state      <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {3'd0, o_stat, o_bot, o_top, o_ch};

endmodule

`default_nettype wire
